// ===== src/fsssd_pkg.sv =====
// Shared types, constants and the hex-to-segment decode for the framed
// seven-segment scan driver. No dependencies.
`default_nettype none
package fsssd_pkg;

  localparam int unsigned DigitCountDefault = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned SelW = 4;

  localparam logic [7:0] FrameOpen = 8'h3C;   // '<'
  localparam logic [7:0] FrameClose = 8'h3E;  // '>'
  localparam logic [7:0] TimeoutReset = 8'd5;

  typedef enum logic [1:0] {
    OpByte   = 2'd0,
    OpScan   = 2'd1,
    OpSecond = 2'd2
  } opcode_e;

  // one event per beat, decoded from the opcode
  typedef struct packed {
    logic take_byte;
    logic scan_tick;
    logic sec_tick;
  } event_t;

  // gfedcba, active high, dp off
  function automatic logic [7:0] hex_seg(input logic [3:0] n);
    logic [7:0] s;
    case (n)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      4'hF: s = 8'h71;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // ASCII hex digit to segments, anything else blank
  function automatic logic [7:0] char_seg(input logic [7:0] c);
    logic [7:0] s;
    s = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      s = hex_seg(c[3:0]);
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      s = hex_seg(4'(c[3:0] + 4'd9));
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== src/fsssd_frame.sv =====
// Receive window: shifts bytes in, spots a '<' ... '>' frame and decodes
// the enclosed characters. Depends on fsssd_pkg.
`default_nettype none
module fsssd_frame #(
  parameter int unsigned DIGIT_COUNT = fsssd_pkg::DigitCountDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         take_i,
  input  wire logic [7:0]                   rx_byte_i,
  output logic                              load_o,
  output logic [DIGIT_COUNT-1:0][7:0]       patterns_o
);
  import fsssd_pkg::*;

  localparam int unsigned WinLen = DIGIT_COUNT + 2;

  logic [WinLen-1:0][7:0] win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (take_i) begin
      win_q <= {win_q[WinLen-2:0], rx_byte_i};
    end
  end

  // after the shift the oldest byte is today's win_q[WinLen-2]
  assign load_o = take_i && (win_q[WinLen-2] == FrameOpen) && (rx_byte_i == FrameClose);

  // digit i takes the byte that lands at window slot i+1, i.e. win_q[i]
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      patterns_o[i] = char_seg(win_q[i]);
    end
  end

endmodule
`default_nettype wire

// ===== src/fsssd_display.sv =====
// Display state: digit patterns, scan position, seconds countdown, lit flag
// and the timeout register; produces the post-event drive. Depends on fsssd_pkg.
`default_nettype none
module fsssd_display #(
  parameter int unsigned DIGIT_COUNT = fsssd_pkg::DigitCountDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fsssd_pkg::event_t            ev_i,
  input  wire logic                         load_i,
  input  wire logic [DIGIT_COUNT-1:0][7:0]  patterns_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [7:0]                   cfg_timeout_i,
  output logic [7:0]                        segment_drive_o,
  output logic [fsssd_pkg::SelW-1:0]        digit_select_n_o,
  output logic                              display_on_o
);
  import fsssd_pkg::*;

  localparam int unsigned ScanW = $clog2(DIGIT_COUNT);

  logic [DIGIT_COUNT-1:0][7:0] pat_q, pat_d;
  logic [ScanW-1:0]            scan_q, scan_d;
  logic [7:0]                  sec_q, sec_d;
  logic                        lit_q, lit_d;
  logic [7:0]                  timeout_q;

  always_comb begin
    pat_d  = pat_q;
    scan_d = scan_q;
    sec_d  = sec_q;
    lit_d  = lit_q;
    if (load_i) begin
      pat_d = patterns_i;
      sec_d = timeout_q;
      lit_d = 1'b1;
    end
    if (ev_i.scan_tick && lit_q) begin
      scan_d = (scan_q == ScanW'(DIGIT_COUNT - 1)) ? '0 : ScanW'(scan_q + 1'b1);
    end
    if (ev_i.sec_tick && lit_q) begin
      sec_d = sec_q - 8'd1;
      if (sec_d == 8'd0) begin
        lit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        pat_q[i] <= hex_seg(4'(i + 1));
      end
      scan_q    <= '0;
      sec_q     <= TimeoutReset;
      lit_q     <= 1'b1;
      timeout_q <= TimeoutReset;
    end else begin
      pat_q  <= pat_d;
      scan_q <= scan_d;
      sec_q  <= sec_d;
      lit_q  <= lit_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_timeout_i;
      end
    end
  end

  // drive reflects the state after this beat's event
  always_comb begin
    segment_drive_o  = 8'h00;
    digit_select_n_o = '1;
    display_on_o     = lit_d;
    if (lit_d) begin
      segment_drive_o = pat_d[scan_d];
      for (int j = 0; j < SelW; j++) begin
        if (j < DIGIT_COUNT) begin
          digit_select_n_o[j] = (int'(scan_d) != j);
        end else begin
          digit_select_n_o[j] = 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/framed_seven_segment_scan_driver_top.sv =====
// Top level of the framed seven-segment scan driver: opcode decode, frame
// window, display state and the result register. Depends on fsssd_pkg,
// fsssd_frame and fsssd_display.
// An accepted beat's result is in the output register in the next cycle.
// Throughput: one beat per cycle; a new beat is taken whenever the output
// register is empty or being drained in the same cycle.
// Reset: window cleared, digits show 1,2,3,..., scan at digit 0, timeout and
// countdown at 5, display lit, no result pending.
`default_nettype none
module framed_seven_segment_scan_driver_top #(
  parameter int unsigned DIGIT_COUNT = fsssd_pkg::DigitCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [7:0]                         segment_drive_o,
  output logic [fsssd_pkg::SelW-1:0]         digit_select_n_o,
  output logic                               display_on_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [7:0]                    cfg_timeout_seconds_i
);
  import fsssd_pkg::*;

  logic                        accept;
  event_t                      ev;
  logic                        load;
  logic [DIGIT_COUNT-1:0][7:0] patterns;
  logic [7:0]                  seg_d, seg_q;
  logic [SelW-1:0]             sel_d, sel_q;
  logic                        on_d, on_q;
  logic                        out_valid_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ev = '0;
    if (accept) begin
      case (opcode_e'(opcode_i))
        OpByte:   ev.take_byte = 1'b1;
        OpScan:   ev.scan_tick = 1'b1;
        OpSecond: ev.sec_tick  = 1'b1;
        default:  ev = '0;
      endcase
    end
  end

  fsssd_frame #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (ev.take_byte),
    .rx_byte_i (rx_byte_i),
    .load_o    (load),
    .patterns_o(patterns)
  );

  fsssd_display #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_display (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ev_i            (ev),
    .load_i          (load),
    .patterns_i      (patterns),
    .cfg_we_i        (cfg_valid_i),
    .cfg_timeout_i   (cfg_timeout_seconds_i),
    .segment_drive_o (seg_d),
    .digit_select_n_o(sel_d),
    .display_on_o    (on_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seg_q <= seg_d;
      sel_q <= sel_d;
      on_q  <= on_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign segment_drive_o  = seg_q;
  assign digit_select_n_o = sel_q;
  assign display_on_o     = on_q;

endmodule
`default_nettype wire
